[sv/lzhc_pkg.sv]
// shared constants, codes and control types of the lz77 hash chain match finder
`timescale 1ns / 1ps
`default_nettype none

package lzhc_pkg;

    // window, hash and lookahead geometry
    localparam int WIN_BITS   = 16;
    localparam int HASH_BITS  = 12;
    localparam int HEAD_COUNT = 1 << HASH_BITS;
    localparam int HEAD_W     = WIN_BITS + 1;
    localparam int LA_DEPTH   = 8192;
    localparam int LA_BITS    = $clog2(LA_DEPTH);
    localparam int CNT_W      = LA_BITS + 1;

    // token field widths
    localparam int LEN_W      = 13;
    localparam int DIST_W     = 16;
    localparam int TRY_W      = 9;
    localparam int OUT_DATA_W = 40;

    // search limits and constants
    localparam int LEN_CAP    = 4096;
    localparam int CHAIN_CAP  = 256;
    localparam int HASH_MUL   = 4093;
    localparam int NEAR_DIST  = 256;
    localparam int FAR_DIST   = 4096;
    localparam int MIN_AVAIL  = 4;
    localparam int MIN_LEN    = 3;
    localparam int TAIL_BYTES = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAZY_MARGIN = 2'd2;

    // request and token codes
    localparam logic [1:0] REQ_DATA    = 2'd0;
    localparam logic [1:0] REQ_FINAL   = 2'd1;
    localparam logic       TOKEN_LIT   = 1'b0;
    localparam logic       TOKEN_MATCH = 1'b1;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CLR,
        OP_DECIDE,
        OP_SR_INIT0,
        OP_SR_INIT1,
        OP_PAIR_RD,
        OP_HASH_A,
        OP_HASH_B,
        OP_LINK_HEAD,
        OP_CAND,
        OP_CMP_PRIME,
        OP_CMP,
        OP_POST,
        OP_LINK_CHAIN,
        OP_SR_END0,
        OP_SR_END1,
        OP_EMIT,
        OP_INS_WR
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    // datapath status back to the controller
    typedef struct packed {
        logic need_clear;
        logic clr_last;
        logic cnt_zero;
        logic not_ready;
        logic cnt_gt2;
        logic avail_lt4;
        logic cand_go;
        logic lim_zero;
        logic cmp_stop;
        logic res_nz;
        logic out_full;
        logic rem_last;
    } t_stat;

endpackage

`default_nettype wire

[sv/lzhc_ctrl.sv]
// sequencer for acceptance, head clearing, chain search, token emission and insertion
`timescale 1ns / 1ps
`default_nettype none

module lzhc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  lzhc_pkg::t_stat     i_stat,
    output logic                o_in_ready,
    output lzhc_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_CLR_RST,
        S_IDLE,
        S_CLR_NEW,
        S_DECIDE,
        S_SR_INIT,
        S_SR_RD,
        S_SR_HA,
        S_SR_HB,
        S_SR_HD,
        S_SR_HL,
        S_CAND,
        S_CMP_PRIME,
        S_CMP,
        S_POST,
        S_LINK,
        S_SR_END,
        S_EM_RD,
        S_EM_WAIT,
        S_INS_RD,
        S_INS_HA,
        S_INS_HB,
        S_INS_HD,
        S_INS_WR
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;
    lzhc_pkg::t_op w_op;

    // next state and operation decode
    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        w_op     = lzhc_pkg::OP_NONE;
        unique case (r_state)
            S_CLR_RST: begin
                w_op = lzhc_pkg::OP_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = lzhc_pkg::OP_ACCEPT;
                    n_state = i_stat.need_clear ? S_CLR_NEW : S_DECIDE;
                end
            end
            S_CLR_NEW: begin
                w_op = lzhc_pkg::OP_CLR;
                if (i_stat.clr_last) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                w_op = lzhc_pkg::OP_DECIDE;
                if (i_stat.cnt_zero || i_stat.not_ready) begin
                    n_state = S_IDLE;
                end else if (i_stat.cnt_gt2) begin
                    n_second = 1'b0;
                    n_state  = S_SR_INIT;
                end else begin
                    n_state = S_EM_RD;
                end
            end
            S_SR_INIT: begin
                w_op    = r_second ? lzhc_pkg::OP_SR_INIT1 : lzhc_pkg::OP_SR_INIT0;
                n_state = S_SR_RD;
            end
            S_SR_RD: begin
                w_op    = lzhc_pkg::OP_PAIR_RD;
                n_state = i_stat.avail_lt4 ? S_SR_END : S_SR_HA;
            end
            S_SR_HA: begin
                w_op    = lzhc_pkg::OP_HASH_A;
                n_state = S_SR_HB;
            end
            S_SR_HB: begin
                w_op    = lzhc_pkg::OP_HASH_B;
                n_state = S_SR_HD;
            end
            S_SR_HD: begin
                n_state = S_SR_HL;
            end
            S_SR_HL: begin
                w_op    = lzhc_pkg::OP_LINK_HEAD;
                n_state = S_CAND;
            end
            S_CAND: begin
                w_op = lzhc_pkg::OP_CAND;
                if (!i_stat.cand_go) n_state = S_SR_END;
                else if (i_stat.lim_zero) n_state = S_POST;
                else n_state = S_CMP_PRIME;
            end
            S_CMP_PRIME: begin
                w_op    = lzhc_pkg::OP_CMP_PRIME;
                n_state = S_CMP;
            end
            S_CMP: begin
                w_op = lzhc_pkg::OP_CMP;
                if (i_stat.cmp_stop) n_state = S_POST;
            end
            S_POST: begin
                w_op    = lzhc_pkg::OP_POST;
                n_state = S_LINK;
            end
            S_LINK: begin
                w_op    = lzhc_pkg::OP_LINK_CHAIN;
                n_state = S_CAND;
            end
            S_SR_END: begin
                w_op = r_second ? lzhc_pkg::OP_SR_END1 : lzhc_pkg::OP_SR_END0;
                if (!r_second && i_stat.res_nz) begin
                    n_second = 1'b1;
                    n_state  = S_SR_INIT;
                end else begin
                    n_state = S_EM_RD;
                end
            end
            S_EM_RD: begin
                n_state = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                if (!i_stat.out_full) begin
                    w_op    = lzhc_pkg::OP_EMIT;
                    n_state = S_INS_RD;
                end
            end
            S_INS_RD: begin
                w_op    = lzhc_pkg::OP_PAIR_RD;
                n_state = S_INS_HA;
            end
            S_INS_HA: begin
                w_op    = lzhc_pkg::OP_HASH_A;
                n_state = S_INS_HB;
            end
            S_INS_HB: begin
                w_op    = lzhc_pkg::OP_HASH_B;
                n_state = S_INS_HD;
            end
            S_INS_HD: begin
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                w_op    = lzhc_pkg::OP_INS_WR;
                n_state = i_stat.rem_last ? S_IDLE : S_INS_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR_RST;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.op   = w_op;

endmodule

`default_nettype wire

[sv/lzhc_dpath.sv]
// datapath: lookahead, window, chain and head memories, hash unit, compare and token register
`timescale 1ns / 1ps
`default_nettype none

module lzhc_dpath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  lzhc_pkg::t_cmd                           i_cmd,
    input  wire logic                                i_cfg_wr,
    input  wire logic [lzhc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lzhc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic [1:0]                          i_req,
    input  wire logic [7:0]                          i_byte,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [lzhc_pkg::OUT_DATA_W-1:0]          o_out_data,
    output logic                                     o_out_kind,
    output logic                                     o_out_last,
    output lzhc_pkg::t_stat                          o_stat
);

    localparam int WB = lzhc_pkg::WIN_BITS;
    localparam int HB = lzhc_pkg::HASH_BITS;
    localparam int HW = lzhc_pkg::HEAD_W;
    localparam int LB = lzhc_pkg::LA_BITS;
    localparam int CW = lzhc_pkg::CNT_W;
    localparam int LW = lzhc_pkg::LEN_W;
    localparam int DW = lzhc_pkg::DIST_W;
    localparam int TW = lzhc_pkg::TRY_W;
    localparam int MIX_W = 20;
    localparam int PROD_W = 32;
    localparam int PAD_W = lzhc_pkg::OUT_DATA_W - 8 - LW - DW;

    // configuration
    logic [TW-1:0]  r_chain_limit;
    logic [LW-1:0]  r_max_match;
    logic [3:0]     r_lazy;

    // stream control state
    logic [WB-1:0]  r_wp;
    logic [LB-1:0]  r_base;
    logic [CW-1:0]  r_cnt;
    logic           r_end;
    logic [HB-1:0]  r_clr;
    logic           r_out_vld;

    // search and insertion working registers
    logic           r_off;
    logic [CW-1:0]  r_avail;
    logic [LW-1:0]  r_lim;
    logic [TW-1:0]  r_tries;
    logic           r_best_vld;
    logic [LW-1:0]  r_best;
    logic [DW-1:0]  r_bestd;
    logic           r_b1_en;
    logic [7:0]     r_b0;
    logic [MIX_W-1:0] r_hash_t;
    logic [HB-1:0]  r_hash;
    logic [HW-1:0]  r_link;
    logic [WB-1:0]  r_c;
    logic [DW-1:0]  r_d;
    logic [LW-1:0]  r_i;
    logic           r_sel_q;
    logic [LW-1:0]  r_len0;
    logic [DW-1:0]  r_dist0;
    logic           r_done;
    logic [LW-1:0]  r_rem;

    // token register
    logic           r_out_kind;
    logic [7:0]     r_out_lit;
    logic [LW-1:0]  r_out_len;
    logic [DW-1:0]  r_out_dist;
    logic           r_out_done;

    // memories and their registered read data
    logic [7:0]     r_la_mem    [lzhc_pkg::LA_DEPTH];
    logic [7:0]     r_win_mem   [1 << WB];
    logic [HW-1:0]  r_chain_mem [1 << WB];
    logic [HW-1:0]  r_head_mem  [lzhc_pkg::HEAD_COUNT];
    logic [7:0]     r_la_a_q;
    logic [7:0]     r_la_b_q;
    logic [7:0]     r_win_q;
    logic [HW-1:0]  r_chain_q;
    logic [HW-1:0]  r_head_q;

    lzhc_pkg::t_op  w_op;
    logic [LW-1:0]  w_mm;
    logic [LW-1:0]  w_mm4;
    logic [TW-1:0]  w_tries_init;
    logic [CW-1:0]  w_thr;
    logic           w_is_data;
    logic           w_new_stream;
    logic           w_end_eff;
    logic           w_la_room;
    logic           w_la_we;
    logic [LB-1:0]  w_la_waddr;
    logic [LW-1:0]  w_idx;
    logic [LB-1:0]  w_cur;
    logic [LB-1:0]  w_src_la;
    logic           w_sel;
    logic [WB-1:0]  w_win_addr;
    logic [LB-1:0]  w_la_a_addr;
    logic [LB-1:0]  w_la_b_addr;
    logic [7:0]     w_b1;
    logic [MIX_W-1:0] w_mix;
    logic [PROD_W-1:0] w_prod;
    logic [WB-1:0]  w_cand_c;
    logic [DW-1:0]  w_cand_d;
    logic           w_eq;
    logic [LW-1:0]  w_adj;
    logic [LW-1:0]  w_res;
    logic           w_head_we;
    logic [HB-1:0]  w_head_waddr;
    logic [HW-1:0]  w_head_wdata;

    assign w_op = i_cmd.op;

    // effective register values
    always_comb begin
        w_mm = (r_max_match > LW'(lzhc_pkg::LEN_CAP)) ? LW'(lzhc_pkg::LEN_CAP) : r_max_match;
        w_tries_init = (r_chain_limit > TW'(lzhc_pkg::CHAIN_CAP)) ?
                       TW'(lzhc_pkg::CHAIN_CAP) : r_chain_limit;
        w_mm4 = (w_mm < LW'(lzhc_pkg::MIN_AVAIL)) ? LW'(lzhc_pkg::MIN_AVAIL) : w_mm;
        w_thr = CW'(w_mm4) + CW'(lzhc_pkg::MIN_LEN);
    end

    // input transaction bookkeeping
    always_comb begin
        w_is_data    = (i_req == lzhc_pkg::REQ_DATA) || (i_req == lzhc_pkg::REQ_FINAL);
        w_new_stream = r_end && (r_cnt == '0);
        w_end_eff    = r_end && !w_new_stream;
        w_la_room    = (r_cnt < CW'(lzhc_pkg::LA_DEPTH));
        w_la_we      = (w_op == lzhc_pkg::OP_ACCEPT) && w_is_data && !w_end_eff && w_la_room;
        w_la_waddr   = r_base + r_cnt[LB-1:0];
    end

    // compare addressing: index r_i+1 while comparing, index 0 when priming
    always_comb begin
        w_idx      = (w_op == lzhc_pkg::OP_CMP) ? (r_i + LW'(1)) : '0;
        w_cur      = r_base + LB'(r_off) + LB'(w_idx);
        w_src_la   = w_cur - LB'(r_d);
        w_sel      = (DW'(w_idx) >= r_d);
        w_win_addr = r_c + WB'(w_idx);
        case (w_op)
            lzhc_pkg::OP_PAIR_RD: begin
                w_la_a_addr = r_base + LB'(r_off);
                w_la_b_addr = r_base + LB'(r_off) + LB'(1);
            end
            lzhc_pkg::OP_CMP_PRIME, lzhc_pkg::OP_CMP: begin
                w_la_a_addr = w_cur;
                w_la_b_addr = w_src_la;
            end
            default: begin
                w_la_a_addr = r_base;
                w_la_b_addr = w_src_la;
            end
        endcase
    end

    // hash of a byte pair, two registered multiply stages
    always_comb begin
        w_b1   = r_b1_en ? r_la_b_q : 8'd0;
        w_mix  = MIX_W'(r_la_a_q) * MIX_W'(lzhc_pkg::HASH_MUL) + MIX_W'(w_b1);
        w_prod = PROD_W'(r_hash_t) * PROD_W'(lzhc_pkg::HASH_MUL);
    end

    // candidate, compare and result evaluation
    always_comb begin
        w_cand_c = r_link[WB-1:0];
        w_cand_d = DW'(r_wp - w_cand_c);
        w_eq     = ((r_sel_q ? r_la_b_q : r_win_q) == r_la_a_q);
        w_adj    = r_i;
        if ((r_i >= LW'(1)) && (r_i < LW'(lzhc_pkg::MIN_AVAIL))) begin
            if ((r_d > DW'(lzhc_pkg::NEAR_DIST)) && (r_i < LW'(lzhc_pkg::MIN_LEN))) w_adj = '0;
            if ((r_d > DW'(lzhc_pkg::FAR_DIST)) && (r_i < LW'(lzhc_pkg::MIN_AVAIL))) w_adj = '0;
        end
        w_res = (r_best_vld && (r_best >= LW'(lzhc_pkg::MIN_LEN))) ? r_best : '0;
    end

    // head table write: clearing pass or insertion
    always_comb begin
        w_head_we    = (w_op == lzhc_pkg::OP_CLR) || (w_op == lzhc_pkg::OP_INS_WR);
        w_head_waddr = (w_op == lzhc_pkg::OP_CLR) ? r_clr : r_hash;
        w_head_wdata = (w_op == lzhc_pkg::OP_CLR) ? '0 : {1'b1, r_wp};
    end

    // lookahead memory, two read ports
    always_ff @(posedge i_clk) begin
        if (w_la_we) r_la_mem[w_la_waddr] <= i_byte;
        r_la_a_q <= r_la_mem[w_la_a_addr];
        r_la_b_q <= r_la_mem[w_la_b_addr];
    end

    // window memory
    always_ff @(posedge i_clk) begin
        if (w_op == lzhc_pkg::OP_INS_WR) r_win_mem[r_wp] <= r_b0;
        r_win_q <= r_win_mem[w_win_addr];
    end

    // chain link memory
    always_ff @(posedge i_clk) begin
        if (w_op == lzhc_pkg::OP_INS_WR) r_chain_mem[r_wp] <= r_head_q;
        r_chain_q <= r_chain_mem[r_c];
    end

    // hash head memory
    always_ff @(posedge i_clk) begin
        if (w_head_we) r_head_mem[w_head_waddr] <= w_head_wdata;
        r_head_q <= r_head_mem[r_hash];
    end

    // control state, configuration and token valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_limit <= TW'(lzhc_pkg::CHAIN_CAP);
            r_max_match   <= LW'(lzhc_pkg::LEN_CAP);
            r_lazy        <= 4'd2;
            r_wp          <= '0;
            r_base        <= '0;
            r_cnt         <= '0;
            r_end         <= 1'b0;
            r_clr         <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                unique case (i_cfg_index)
                    lzhc_pkg::CFG_CHAIN_LIMIT: r_chain_limit <= i_cfg_data[TW-1:0];
                    lzhc_pkg::CFG_MAX_MATCH:   r_max_match   <= i_cfg_data[LW-1:0];
                    lzhc_pkg::CFG_LAZY_MARGIN: r_lazy        <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (r_out_vld && i_out_ready) r_out_vld <= 1'b0;
            case (w_op)
                lzhc_pkg::OP_ACCEPT: begin
                    if (w_is_data) begin
                        if (w_new_stream) r_wp <= '0;
                        if (w_la_we) r_cnt <= r_cnt + CW'(1);
                        r_end <= w_end_eff || (i_req == lzhc_pkg::REQ_FINAL);
                    end
                end
                lzhc_pkg::OP_CLR: begin
                    r_clr <= r_clr + HB'(1);
                end
                lzhc_pkg::OP_EMIT: begin
                    r_out_vld <= 1'b1;
                end
                lzhc_pkg::OP_INS_WR: begin
                    r_wp   <= r_wp + WB'(1);
                    r_base <= r_base + LB'(1);
                    r_cnt  <= r_cnt - CW'(1);
                end
                default: ;
            endcase
        end
    end

    // working registers of search, insertion and the token
    always_ff @(posedge i_clk) begin
        r_sel_q <= w_sel;
        case (w_op)
            lzhc_pkg::OP_DECIDE: begin
                r_len0  <= '0;
                r_dist0 <= '0;
                r_done  <= r_end && (r_cnt == CW'(1));
            end
            lzhc_pkg::OP_SR_INIT0, lzhc_pkg::OP_SR_INIT1: begin
                r_off      <= (w_op == lzhc_pkg::OP_SR_INIT1);
                r_avail    <= r_cnt - CW'(lzhc_pkg::TAIL_BYTES)
                              - CW'(w_op == lzhc_pkg::OP_SR_INIT1);
                r_tries    <= w_tries_init;
                r_best_vld <= 1'b0;
                r_best     <= '0;
                r_bestd    <= '0;
            end
            lzhc_pkg::OP_PAIR_RD: begin
                r_b1_en <= (r_cnt > (CW'(r_off) + CW'(1)));
                r_lim   <= (CW'(w_mm) < r_avail) ? w_mm : LW'(r_avail);
            end
            lzhc_pkg::OP_HASH_A: begin
                r_b0     <= r_la_a_q;
                r_hash_t <= w_mix;
            end
            lzhc_pkg::OP_HASH_B: begin
                r_hash <= w_prod[12 +: HB];
            end
            lzhc_pkg::OP_LINK_HEAD: begin
                r_link <= r_head_q;
            end
            lzhc_pkg::OP_CAND: begin
                r_c     <= w_cand_c;
                r_d     <= w_cand_d;
                r_i     <= '0;
                r_tries <= r_tries - TW'(1);
            end
            lzhc_pkg::OP_CMP: begin
                if (w_eq) r_i <= r_i + LW'(1);
            end
            lzhc_pkg::OP_POST: begin
                if (!r_best_vld || (w_adj > r_best)) begin
                    r_best     <= w_adj;
                    r_bestd    <= r_d;
                    r_best_vld <= 1'b1;
                end
            end
            lzhc_pkg::OP_LINK_CHAIN: begin
                r_link <= r_chain_q;
            end
            lzhc_pkg::OP_SR_END0: begin
                r_len0  <= w_res;
                r_dist0 <= r_bestd;
            end
            lzhc_pkg::OP_SR_END1: begin
                // a clearly longer match one byte on defers to a literal
                if ((w_res != '0) &&
                    ({1'b0, w_res} > ({1'b0, r_len0} + (LW+1)'(r_lazy)))) begin
                    r_len0 <= '0;
                end
            end
            lzhc_pkg::OP_EMIT: begin
                r_out_kind <= (r_len0 != '0) ? lzhc_pkg::TOKEN_MATCH : lzhc_pkg::TOKEN_LIT;
                r_out_lit  <= (r_len0 != '0) ? 8'd0 : r_la_a_q;
                r_out_len  <= r_len0;
                r_out_dist <= (r_len0 != '0) ? r_dist0 : '0;
                r_out_done <= r_done;
                r_rem      <= (r_len0 != '0) ? r_len0 : LW'(1);
                r_off      <= 1'b0;
            end
            lzhc_pkg::OP_INS_WR: begin
                r_rem <= r_rem - LW'(1);
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb begin
        o_stat.need_clear = w_is_data && w_new_stream;
        o_stat.clr_last   = (r_clr == {HB{1'b1}});
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.not_ready  = !r_end && (r_cnt < w_thr);
        o_stat.cnt_gt2    = (r_cnt > CW'(lzhc_pkg::TAIL_BYTES));
        o_stat.avail_lt4  = (r_avail < CW'(lzhc_pkg::MIN_AVAIL));
        o_stat.cand_go    = r_link[WB] && (r_tries != '0) && (w_cand_d != '0);
        o_stat.lim_zero   = (r_lim == '0);
        o_stat.cmp_stop   = !w_eq || ((r_i + LW'(1)) == r_lim);
        o_stat.res_nz     = (w_res != '0);
        o_stat.out_full   = r_out_vld;
        o_stat.rem_last   = (r_rem == LW'(1));
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = {{PAD_W{1'b0}}, r_out_dist, r_out_len, r_out_lit};
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_done;

endmodule

`default_nettype wire

[sv/lz77_hash_chain_match_finder_core.sv]
// top level: lz77 hash chain match finder with lazy matching, stream ports and register port
// Reset: synchronous active-low, then a pass over all 4096 hash heads empties them; a data byte
// that opens a new stream triggers another such pass before its decision.
// Flow: only a decision when no token is due; else the decision, each search (hash, then a
// compare per candidate), then the token is emitted and each byte it consumes is inserted.
// Throughput: one item at a time; a token register lets the next item in while one waits.
`timescale 1ns / 1ps
`default_nettype none

module lz77_hash_chain_match_finder_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input stream
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  wire logic [7:0]                           i_s_axis_tdata,  // data_byte
    input  wire logic [1:0]                           i_s_axis_tuser,  // req_type
    // token stream
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // literal_byte [7:0], match_length [20:8], match_distance [36:21], zero [39:37]
    output logic [lzhc_pkg::OUT_DATA_W-1:0]           o_m_axis_tdata,
    output logic                                      o_m_axis_tuser,  // token_kind
    output logic                                      o_m_axis_tlast,  // stream_done
    // register writes
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [lzhc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [lzhc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    lzhc_pkg::t_cmd  w_cmd;
    lzhc_pkg::t_stat w_stat;

    // the user must write registers only while idle (not enforced here), so writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    lzhc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // memories, search and token datapath
    lzhc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_s_axis_tuser),
        .i_byte      (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_kind  (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast),
        .o_stat      (w_stat)
    );

endmodule

`default_nettype wire

[tb/lz77_hash_chain_match_finder_core_test.sv]
// self-checking testbench for the lz77 hash chain match finder core
`timescale 1ns / 1ps
`default_nettype none

module lz77_hash_chain_match_finder_core_test;
    import lzhc_pkg::*;

    // request codes not named in the package
    localparam logic [1:0] REQ_DRAIN = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int unsigned ADDR_MASK = 32'h0000_FFFF;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int SETTLE_CYCLES  = 5 * LEN_CAP + 600;
    localparam int ITEM_TARGET    = 950;
    localparam int QUIET_FROM     = 850;

    typedef struct packed {
        logic              kind;
        logic [7:0]        lit;
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] dst;
        logic              done;
    } token_t;

    typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_TOKEN} row_mode_t;

    typedef struct packed {
        logic [1:0] rt;
        logic [7:0] b;
        row_mode_t  mode;
        token_t     tok;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata;
    logic [1:0]            i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lz77_hash_chain_match_finder_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow state of the match finder
    bit [7:0]    window_mem [65536];
    bit [16:0]   link_mem   [65536];
    bit [16:0]   head_mem   [4096];
    bit [7:0]    la_mem     [8192];
    int unsigned wpos;
    int unsigned la_cnt;
    bit          ended;
    int unsigned cfg_chain;
    int unsigned cfg_mm;
    int unsigned cfg_lazy;

    token_t   token_q [$];
    dir_row_t dir_tab [$];
    int       errors;
    int       item_cnt;
    int       tok_cnt;
    bit       quiet;

    function automatic int unsigned pair_hash(int unsigned a, int unsigned b);
        bit [31:0] h;
        h = (a * 32'd4093 + b) * 32'd4093;
        return h[23:12];
    endfunction

    function automatic void window_insert(int unsigned b0, int unsigned b1);
        int unsigned h;
        int unsigned p;
        h = pair_hash(b0, b1);
        p = wpos & ADDR_MASK;
        window_mem[p] = b0[7:0];
        link_mem[p]   = head_mem[h];
        head_mem[h]   = {1'b1, p[15:0]};
        wpos = (p + 1) & ADDR_MASK;
    endfunction

    // best match at lookahead offset off, 0 when shorter than 3
    function automatic int unsigned match_len(int unsigned off, int unsigned avail,
                                              int unsigned mm, output int unsigned bdist);
        int          best;
        int unsigned lim, tries, c, d, i, bestd;
        bit [16:0]   link;
        bit [7:0]    src;
        best  = -1;
        bestd = 0;
        bdist = 0;
        if (avail < 4) return 0;
        lim   = (mm < avail) ? mm : avail;
        tries = (cfg_chain > CHAIN_CAP) ? CHAIN_CAP : cfg_chain;
        link  = head_mem[pair_hash(la_mem[off], la_mem[off + 1])];
        while (link[16] && tries > 0) begin
            c = link[15:0];
            d = (wpos - c) & ADDR_MASK;
            tries--;
            if (d == 0) d = 65536;
            if (d >= 65536) break;
            i = 0;
            while (i < lim) begin
                src = (i < d) ? window_mem[(c + i) & ADDR_MASK] : la_mem[off + i - d];
                if (src != la_mem[off + i]) break;
                i++;
            end
            // short far matches are worthless
            if (i >= 1 && i < 4) begin
                if (d > NEAR_DIST && i < 3) i = 0;
                if (d > FAR_DIST && i < 4) i = 0;
            end
            if (int'(i) > best) begin
                best  = int'(i);
                bestd = d;
            end
            link = link_mem[c];
        end
        bdist = bestd;
        return (best > 2) ? best : 0;
    endfunction

    function automatic void absorb(int unsigned n);
        int unsigned k, nx;
        for (k = 0; k < n; k++) begin
            nx = (k + 1 < la_cnt) ? la_mem[k + 1] : 0;
            window_insert(la_mem[k], nx);
        end
        for (k = 0; k + n < la_cnt; k++) la_mem[k] = la_mem[k + n];
        la_cnt -= n;
    endfunction

    // one accepted request through the shadow model
    task automatic tokenise_step(input logic [1:0] rt, input logic [7:0] b,
                                 output bit has, output token_t t);
        int unsigned mm, len, mdist, d1, nxt, avail;
        bit          done;
        mm    = (cfg_mm > LEN_CAP) ? LEN_CAP : cfg_mm;
        len   = 0;
        mdist = 0;
        done  = 1'b0;
        has   = 1'b0;
        t     = '0;
        if (rt == REQ_DATA || rt == REQ_FINAL) begin
            // data after a fully drained stream opens a new one
            if (ended && la_cnt == 0) begin
                foreach (head_mem[j]) head_mem[j] = '0;
                wpos  = 0;
                ended = 1'b0;
            end
            if (!ended) begin
                if (la_cnt < LA_DEPTH) begin
                    la_mem[la_cnt] = b;
                    la_cnt++;
                end
                if (rt == REQ_FINAL) ended = 1'b1;
            end
        end
        if (la_cnt == 0) return;
        if (!ended && la_cnt < ((mm < 4) ? 4 : mm) + 3) return;
        if (la_cnt > 2) begin
            avail = la_cnt - 2;
            len = match_len(0, avail, mm, mdist);
            if (len != 0) begin
                // lazy check one byte further on
                nxt = match_len(1, avail - 1, mm, d1);
                if (nxt != 0 && nxt > len + cfg_lazy) len = 0;
            end
        end else begin
            done = ended && la_cnt == 1;
        end
        has = 1'b1;
        if (len != 0) begin
            t.kind = TOKEN_MATCH;
            t.len  = len[LEN_W-1:0];
            t.dst  = mdist[DIST_W-1:0];
            absorb(len);
        end else begin
            t.kind = TOKEN_LIT;
            t.lit  = la_mem[0];
            t.done = done;
            absorb(1);
        end
    endtask

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // send one request transaction and update the expectations
    task automatic send_req(input logic [1:0] rt, input logic [7:0] b,
                            input row_mode_t mode, input token_t typed);
        bit     has;
        token_t t;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= rt;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tokenise_step(rt, b, has, t);
        if (mode == ROW_TOKEN) token_q.push_back(typed);
        else if (mode == ROW_PRED && has) token_q.push_back(t);
        item_cnt++;
        if (item_cnt >= QUIET_FROM) quiet = 1'b1;
    endtask

    // hold the sender until every token is out
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (token_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CHAIN_LIMIT: cfg_chain = val & 32'h1FF;
            CFG_MAX_MATCH:   cfg_mm    = val & 32'h1FFF;
            CFG_LAZY_MARGIN: cfg_lazy  = val & 32'hF;
            default: ;
        endcase
    endtask

    function automatic token_t lit_tok(logic [7:0] b, logic done);
        token_t t;
        t      = '0;
        t.kind = TOKEN_LIT;
        t.lit  = b;
        t.done = done;
        return t;
    endfunction

    task automatic row(input logic [1:0] rt, input logic [7:0] b,
                       input row_mode_t mode, input token_t t);
        dir_tab.push_back('{rt: rt, b: b, mode: mode, tok: t});
    endtask

    // one stream of random content, then drained to empty
    task automatic random_stream(input int len, input int alpha);
        logic [7:0] sym [8];
        logic [7:0] b;
        int         k;
        for (k = 0; k < 8; k++) sym[k] = 8'($urandom_range(0, 255));
        for (k = 0; k < len; k++) begin
            b = (alpha == 0) ? 8'($urandom_range(0, 255)) : sym[$urandom_range(0, alpha - 1)];
            if ($urandom_range(0, 39) == 0)
                send_req($urandom_range(0, 1) ? REQ_DRAIN : REQ_SPARE, 8'($urandom),
                         ROW_PRED, '0);
            if (k == len / 2 && $urandom_range(0, 9) == 0) settle();
            send_req((k == len - 1) ? REQ_FINAL : REQ_DATA, b, ROW_PRED, '0);
        end
        while (la_cnt != 0) begin
            // data sent while tokens remain only drains
            if ($urandom_range(0, 7) == 0)
                send_req(2'($urandom_range(0, 1)), 8'($urandom), ROW_PRED, '0);
            else
                send_req($urandom_range(0, 1) ? REQ_DRAIN : REQ_SPARE, 8'($urandom),
                         ROW_PRED, '0);
        end
        if ($urandom_range(0, 3) == 0) send_req(REQ_DRAIN, 8'($urandom), ROW_PRED, '0);
    endtask

    // token receiver with stall bursts
    int stall_left;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(1, 16);
            i_m_axis_tready <= quiet || ($urandom_range(0, 3) != 0);
        end else begin
            stall_left--;
        end
    end

    // token checker
    always @(posedge i_clk) begin
        token_t e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            tok_cnt++;
            if (token_q.size() == 0) begin
                report($sformatf("token %0d arrived with none expected", tok_cnt));
            end else begin
                e = token_q.pop_front();
                if (o_m_axis_tuser !== e.kind)
                    report($sformatf("token %0d kind %b exp %b", tok_cnt, o_m_axis_tuser,
                                     e.kind));
                if (o_m_axis_tdata[7:0] !== e.lit)
                    report($sformatf("token %0d literal %h exp %h", tok_cnt,
                                     o_m_axis_tdata[7:0], e.lit));
                if (o_m_axis_tdata[20:8] !== e.len)
                    report($sformatf("token %0d length %0d exp %0d", tok_cnt,
                                     o_m_axis_tdata[20:8], e.len));
                if (o_m_axis_tdata[36:21] !== e.dst)
                    report($sformatf("token %0d distance %0d exp %0d", tok_cnt,
                                     o_m_axis_tdata[36:21], e.dst));
                if (o_m_axis_tdata[39:37] !== 3'b000)
                    report($sformatf("token %0d pad bits %b", tok_cnt,
                                     o_m_axis_tdata[39:37]));
                if (o_m_axis_tlast !== e.done)
                    report($sformatf("token %0d done %b exp %b", tok_cnt, o_m_axis_tlast,
                                     e.done));
            end
        end
    end

    // watchdog on cycles without any transaction
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin : stimulus
        int unsigned phase_cfg [8][3];
        int          p, mm_eff, budget;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= REQ_DATA;
        i_m_axis_tready <= 1'b1;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_CHAIN_LIMIT;
        i_cfg_data      <= '0;
        stall_left  = 0;
        idle_cycles = 0;
        errors   = 0;
        item_cnt = 0;
        tok_cnt  = 0;
        quiet    = 1'b0;
        foreach (head_mem[j]) head_mem[j] = '0;
        wpos      = 0;
        la_cnt    = 0;
        ended     = 1'b0;
        cfg_chain = CHAIN_CAP;
        cfg_mm    = LEN_CAP;
        cfg_lazy  = 2;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings
        row(REQ_DATA,  8'h00, ROW_NONE,  '0);
        row(REQ_DATA,  8'hFF, ROW_NONE,  '0);
        row(REQ_FINAL, 8'h41, ROW_TOKEN, lit_tok(8'h00, 1'b0));
        row(REQ_DRAIN, 8'h00, ROW_TOKEN, lit_tok(8'hFF, 1'b0));
        row(REQ_SPARE, 8'hAA, ROW_TOKEN, lit_tok(8'h41, 1'b1));
        row(REQ_DRAIN, 8'h00, ROW_NONE,  '0);
        row(REQ_SPARE, 8'hFF, ROW_NONE,  '0);
        // single byte stream
        row(REQ_FINAL, 8'h7E, ROW_TOKEN, lit_tok(8'h7E, 1'b1));
        // repeating pattern gives overlapping matches
        row(REQ_DATA,  8'h61, ROW_NONE,  '0);
        row(REQ_DATA,  8'h62, ROW_NONE,  '0);
        row(REQ_DATA,  8'h63, ROW_NONE,  '0);
        row(REQ_DATA,  8'h61, ROW_NONE,  '0);
        row(REQ_DATA,  8'h62, ROW_NONE,  '0);
        row(REQ_DATA,  8'h63, ROW_NONE,  '0);
        row(REQ_DATA,  8'h61, ROW_NONE,  '0);
        row(REQ_DATA,  8'h62, ROW_NONE,  '0);
        row(REQ_FINAL, 8'h63, ROW_PRED,  '0);
        row(REQ_DATA,  8'h55, ROW_PRED,  '0);
        repeat (7) row(REQ_DRAIN, 8'h00, ROW_PRED, '0);
        foreach (dir_tab[k]) send_req(dir_tab[k].rt, dir_tab[k].b, dir_tab[k].mode,
                                      dir_tab[k].tok);
        while (la_cnt != 0) send_req(REQ_DRAIN, 8'h00, ROW_PRED, '0);

        // register settings per phase: chain_limit, max_match, lazy_margin
        phase_cfg = '{'{1, 4, 0}, '{256, 4096, 15}, '{0, 16, 2}, '{8, 16, 3},
                      '{511, 8191, 1}, '{32, 2, 4}, '{255, 64, 0}, '{64, 8, 7}};
        for (p = 0; p < 8; p++) begin
            settle();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            write_reg(CFG_CHAIN_LIMIT, phase_cfg[p][0]);
            write_reg(CFG_MAX_MATCH,   phase_cfg[p][1]);
            write_reg(CFG_LAZY_MARGIN, phase_cfg[p][2]);
            mm_eff = (phase_cfg[p][1] > LEN_CAP) ? LEN_CAP : phase_cfg[p][1];
            budget = item_cnt + (ITEM_TARGET - item_cnt) / (8 - p);
            while (item_cnt < budget) begin
                if (mm_eff >= 1000)
                    random_stream($urandom_range(1, 40), $urandom_range(0, 4));
                else
                    random_stream($urandom_range(1, 120),
                                  $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 8));
            end
        end

        // wait for the last tokens, then a margin for strays
        i_s_axis_tvalid <= 1'b0;
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (errors == 0 && token_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
sv/lzhc_pkg.sv
sv/lzhc_ctrl.sv
sv/lzhc_dpath.sv
sv/lz77_hash_chain_match_finder_core.sv
tb/lz77_hash_chain_match_finder_core_test.sv
